// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants, types and the microcode table of the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int FIELD_WIDTH   = 32;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);
  localparam int BIT_CNT_W     = $clog2(OPERAND_WIDTH + 1);
  localparam int STEP_W        = 4;

  typedef logic [OPERAND_WIDTH-1:0] word_t;
  typedef logic [STEP_W-1:0]        step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_CHECK  = 4'd1;
  localparam step_t STEP_INIT   = 4'd2;
  localparam step_t STEP_REDUCE = 4'd3;
  localparam step_t STEP_TEST   = 4'd4;
  localparam step_t STEP_MULR   = 4'd5;
  localparam step_t STEP_CAPR   = 4'd6;
  localparam step_t STEP_SQR    = 4'd7;
  localparam step_t STEP_CAPS   = 4'd8;
  localparam step_t STEP_LOOP   = 4'd9;
  localparam step_t STEP_OUT    = 4'd10;
  localparam step_t STEP_RET    = 4'd11;
  localparam step_t STEP_ERR    = 4'd12;
  localparam step_t STEP_ERET   = 4'd13;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_LOAD    = 4'd1,
    ACT_INIT    = 4'd2,
    ACT_MUL_RS  = 4'd3,
    ACT_MUL_SS  = 4'd4,
    ACT_CAP_S   = 4'd5,
    ACT_CAP_SQ  = 4'd6,
    ACT_CAP_R   = 4'd7,
    ACT_OUT     = 4'd8,
    ACT_OUT_ERR = 4'd9
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER       = 3'd0,
    COND_ALWAYS      = 3'd1,
    COND_NO_INPUT    = 3'd2,
    COND_MOD_ZERO    = 3'd3,
    COND_MUL_BUSY    = 3'd4,
    COND_EXP_BIT_CLR = 3'd5,
    COND_BITS_LEFT   = 3'd6,
    COND_OUT_FULL    = 3'd7
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic no_input;
    logic mod_zero;
    logic mul_busy;
    logic exp_bit_clr;
    logic bits_left;
    logic out_full;
  } cond_flags_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
  } mul_stat_t;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      STEP_IDLE:   w = ucode_t'{ACT_LOAD,    COND_NO_INPUT,    STEP_IDLE};
      STEP_CHECK:  w = ucode_t'{ACT_NONE,    COND_MOD_ZERO,    STEP_ERR};
      STEP_INIT:   w = ucode_t'{ACT_INIT,    COND_NEVER,       STEP_IDLE};
      STEP_REDUCE: w = ucode_t'{ACT_CAP_S,   COND_MUL_BUSY,    STEP_REDUCE};
      STEP_TEST:   w = ucode_t'{ACT_NONE,    COND_EXP_BIT_CLR, STEP_SQR};
      STEP_MULR:   w = ucode_t'{ACT_MUL_RS,  COND_NEVER,       STEP_IDLE};
      STEP_CAPR:   w = ucode_t'{ACT_CAP_R,   COND_MUL_BUSY,    STEP_CAPR};
      STEP_SQR:    w = ucode_t'{ACT_MUL_SS,  COND_NEVER,       STEP_IDLE};
      STEP_CAPS:   w = ucode_t'{ACT_CAP_SQ,  COND_MUL_BUSY,    STEP_CAPS};
      STEP_LOOP:   w = ucode_t'{ACT_NONE,    COND_BITS_LEFT,   STEP_TEST};
      STEP_OUT:    w = ucode_t'{ACT_OUT,     COND_OUT_FULL,    STEP_OUT};
      STEP_RET:    w = ucode_t'{ACT_NONE,    COND_ALWAYS,      STEP_IDLE};
      STEP_ERR:    w = ucode_t'{ACT_OUT_ERR, COND_OUT_FULL,    STEP_ERR};
      STEP_ERET:   w = ucode_t'{ACT_NONE,    COND_ALWAYS,      STEP_IDLE};
      default:     w = ucode_t'{ACT_NONE,    COND_ALWAYS,      STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// modexp_mulmod
// Shift-add modular multiplier, one multiplier bit per cycle, MSB first,
// with a reduction after the doubling and after the add.
// ----------------------------------------------------------------------------
module modexp_mulmod
  import modexp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mul_ctrl_t ctrl,
  input  word_t     m,
  output mul_stat_t stat,
  output word_t     product
);

  word_t                  a_r, a_nxt;
  word_t                  b_r, b_nxt;
  word_t                  acc_r, acc_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;

  logic [OPERAND_WIDTH:0] m_ext;
  logic [OPERAND_WIDTH:0] dbl;
  logic [OPERAND_WIDTH:0] t1;
  logic [OPERAND_WIDTH:0] sum;
  logic [OPERAND_WIDTH:0] t2;

  always_comb begin
    m_ext = {1'b0, m};
    dbl   = {acc_r, 1'b0};
    t1    = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum   = t1 + {1'b0, a_r};
    t2    = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctrl.start) begin
      a_nxt    = ctrl.a;
      b_nxt    = ctrl.b;
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(OPERAND_WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = b_r[OPERAND_WIDTH-1] ? t2[OPERAND_WIDTH-1:0] : t1[OPERAND_WIDTH-1:0];
      b_nxt   = {b_r[OPERAND_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign product   = acc_r;

endmodule

// ===== rtl/modexp_seq.sv =====
// ----------------------------------------------------------------------------
// modexp_seq
// Microcode sequencer: step counter, control word table and conditional
// jumps.
// ----------------------------------------------------------------------------
module modexp_seq
  import modexp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cond_flags_t flags,
  output ucode_t      ucode,
  output logic        fire
);

  step_t pc_r, pc_nxt;
  logic  take;

  assign ucode = ucode_rom(pc_r);

  always_comb begin
    case (ucode.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = flags.no_input;
      COND_MOD_ZERO:    take = flags.mod_zero;
      COND_MUL_BUSY:    take = flags.mul_busy;
      COND_EXP_BIT_CLR: take = flags.exp_bit_clr;
      COND_BITS_LEFT:   take = flags.bits_left;
      COND_OUT_FULL:    take = flags.out_full;
      default:          take = 1'b0;
    endcase
  end

  // hold the action while a step loops on itself
  assign fire   = !(take && (ucode.target == pc_r));
  assign pc_nxt = take ? ucode.target : (pc_r + step_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
//
// Input channel in_*: one word carries base, exponent and modulus. Output
// channel out_*: one word per input with the power and an error flag; a
// zero modulus returns 0 with out_tuser set.
// A microcoded sequencer drives a shift-add modular multiplier that takes
// one multiplier bit per cycle. With W = OPERAND_WIDTH, all W exponent bits
// are scanned whatever the exponent: a clear bit costs a square, a set bit a
// multiply and a square. Setup and base reduction come before the loop and
// the output after it; a zero modulus goes straight to the error output.
// One item is processed at a time; in_tready is high only in the idle step.
// The result sits in an output register, so the next word is accepted while
// it waits; a stalled receiver holds the sequencer at its output step.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [3*FIELD_WIDTH-1:0] in_tdata,   // base_value, exponent_value, modulus_value
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [FIELD_WIDTH-1:0]   out_tdata,  // power_result
  output logic                     out_tuser   // zero_modulus_error
);

  ucode_t      ucode;
  logic        fire;
  cond_flags_t flags;
  mul_ctrl_t   mul_ctrl;
  mul_stat_t   mul_stat;
  word_t       product;

  word_t                b_r, b_nxt;
  word_t                e_r, e_nxt;
  word_t                m_r, m_nxt;
  word_t                r_r, r_nxt;
  word_t                s_r, s_nxt;
  logic [BIT_CNT_W-1:0] bits_r, bits_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FIELD_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                 out_err_r, out_err_nxt;

  word_t one_mod;
  logic  act_go;

  modexp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ucode (ucode),
    .fire  (fire)
  );

  modexp_mulmod u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mul_ctrl),
    .m       (m_r),
    .stat    (mul_stat),
    .product (product)
  );

  assign in_tready = (ucode.act == ACT_LOAD);
  assign one_mod   = (m_r == word_t'(1)) ? '0 : word_t'(1);
  assign act_go    = fire;

  always_comb begin
    flags.no_input    = !in_tvalid;
    flags.mod_zero    = (m_r == '0);
    flags.mul_busy    = mul_stat.busy;
    flags.exp_bit_clr = !e_r[0];
    flags.bits_left   = (bits_r != '0);
    flags.out_full    = out_valid_r && !out_tready;
  end

  always_comb begin
    mul_ctrl.start = 1'b0;
    mul_ctrl.a     = r_r;
    mul_ctrl.b     = s_r;
    case (ucode.act)
      ACT_INIT: begin
        mul_ctrl.start = act_go;
        mul_ctrl.a     = one_mod;
        mul_ctrl.b     = b_r;
      end
      ACT_MUL_RS: begin
        mul_ctrl.start = act_go;
        mul_ctrl.a     = r_r;
        mul_ctrl.b     = s_r;
      end
      ACT_MUL_SS: begin
        mul_ctrl.start = act_go;
        mul_ctrl.a     = s_r;
        mul_ctrl.b     = s_r;
      end
      default: begin
        mul_ctrl.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    b_nxt         = b_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    bits_nxt      = bits_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;
    if (act_go) begin
      case (ucode.act)
        ACT_LOAD: begin
          b_nxt = word_t'(in_tdata[FIELD_WIDTH-1:0]);
          e_nxt = word_t'(in_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]);
          m_nxt = word_t'(in_tdata[3*FIELD_WIDTH-1:2*FIELD_WIDTH]);
        end
        ACT_INIT: begin
          r_nxt    = one_mod;
          bits_nxt = BIT_CNT_W'(OPERAND_WIDTH);
        end
        ACT_CAP_S: begin
          s_nxt = product;
        end
        ACT_CAP_R: begin
          r_nxt = product;
        end
        ACT_CAP_SQ: begin
          s_nxt    = product;
          e_nxt    = e_r >> 1;
          bits_nxt = bits_r - BIT_CNT_W'(1);
        end
        ACT_OUT: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = FIELD_WIDTH'(r_r);
          out_err_nxt   = 1'b0;
        end
        ACT_OUT_ERR: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_err_nxt   = 1'b1;
        end
        default: begin
          b_nxt = b_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    b_r        <= b_nxt;
    e_r        <= e_nxt;
    m_r        <= m_nxt;
    r_r        <= r_nxt;
    s_r        <= s_nxt;
    bits_r     <= bits_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error word carries nonzero data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again without processing");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ctrl.start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (ucode.act == ACT_OUT) && fire |-> r_r < m_r)
    else $error("result not reduced by modulus");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for modular_exponentiation.
//
// Words carrying base, exponent and modulus go in through the in_* stream.
// A predictor in this file works out each power by right-to-left
// square-and-multiply, with every product reduced by the modulus, and flags
// a zero modulus. Each accepted input word queues its prediction. The monitor
// compares every out_* word with the oldest prediction, field by field. A
// directed set comes first: zero and all-ones operands, a zero exponent, a
// zero modulus, a modulus of one and bases at or above the modulus. Random
// words with mixed modulus sizes follow. Sender gaps and receiver stalls
// change phase as results arrive, and one long receiver hold-off fills the
// output register and blocks the input.
// ----------------------------------------------------------------------------
module tb
  import modexp_pkg::*;
();

  localparam int RANDOM_WORDS = 268;
  localparam int PHASE_LEN    = 24;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 7000;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 3_200_000;

  typedef logic [FIELD_WIDTH-1:0]   field_t;
  typedef logic [3*FIELD_WIDTH-1:0] operands_t;

  typedef struct packed {
    field_t power;
    logic   mod_error;
  } power_result_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_tvalid = 1'b0;
  logic      in_tready;
  operands_t in_tdata = '0;
  logic      out_tvalid;
  logic      out_tready = 1'b0;
  field_t    out_tdata;
  logic      out_tuser;

  operands_t     pending_words[$];
  power_result_t expected_powers[$];
  int            results_seen = 0;
  int            mismatch_count = 0;
  int            hold_cycles_left = 0;
  logic          hold_done = 1'b0;
  int            cycle_count = 0;

  modular_exponentiation uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic power_result_t predict_power(input operands_t word);
    logic [127:0]  opmask;
    logic [127:0]  b;
    logic [127:0]  e;
    logic [127:0]  m;
    logic [127:0]  acc;
    logic [127:0]  sq;
    power_result_t r;
    opmask = (128'd1 << OPERAND_WIDTH) - 128'd1;
    b = 128'(word[FIELD_WIDTH-1:0]) & opmask;
    e = 128'(word[2*FIELD_WIDTH-1:FIELD_WIDTH]) & opmask;
    m = 128'(word[3*FIELD_WIDTH-1:2*FIELD_WIDTH]) & opmask;
    if (m == 0) begin
      r.power = '0;
      r.mod_error = 1'b1;
      return r;
    end
    acc = 128'd1 % m;
    sq = b % m;
    for (int k = 0; k < OPERAND_WIDTH; k++) begin
      if (e[k]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    r.power = acc[FIELD_WIDTH-1:0];
    r.mod_error = 1'b0;
    return r;
  endfunction

  function automatic operands_t pack_operands(input field_t b, input field_t e, input field_t m);
    return {m, e, b};
  endfunction

  task automatic add_word(input operands_t w);
    pending_words = {pending_words, w};
  endtask

  function automatic int idle_phase();
    return (results_seen / PHASE_LEN) % 4;
  endfunction

  function automatic logic sender_gap();
    int ph;
    ph = idle_phase();
    if (hold_cycles_left != 0) return 1'b0;
    if (ph == 1) return $urandom_range(99) < 63;
    if (ph == 3) return $urandom_range(99) < 27;
    return 1'b0;
  endfunction

  function automatic logic receiver_stall();
    int ph;
    ph = idle_phase();
    if (ph == 2) return $urandom_range(99) < 63;
    if (ph == 3) return $urandom_range(99) < 27;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on result %0d: %s got 0x%0h, want 0x%0h",
             $realtime, results_seen, what, got, want);
    mismatch_count++;
  endtask

  function automatic operands_t random_operands();
    field_t b;
    field_t e;
    field_t m;
    case ($urandom_range(19))
      0:       m = '0;
      1:       m = field_t'(1);
      2, 3, 4: m = field_t'($urandom_range(2, 255));
      5, 6:    m = field_t'($urandom_range(256, 65535));
      default: m = field_t'($urandom);
    endcase
    case ($urandom_range(9))
      0:       b = '0;
      1:       b = m;
      2, 3:    b = (m > 1) ? field_t'($urandom_range(m - 1)) : field_t'($urandom);
      default: b = field_t'($urandom);
    endcase
    case ($urandom_range(9))
      0:       e = '0;
      1, 2:    e = field_t'($urandom_range(15));
      default: e = field_t'($urandom);
    endcase
    return pack_operands(b, e, m);
  endfunction

  // driver: record each accepted word, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) expected_powers = {expected_powers, predict_power(in_tdata)};
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && !sender_gap()) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_words.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each delivered word against the oldest prediction
  always @(posedge clk) begin
    power_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_powers.size() == 0) begin
          report_mismatch("unexpected word, power", out_tdata, 0);
        end else begin
          want = expected_powers.pop_front();
          if (out_tdata !== want.power) report_mismatch("power", out_tdata, want.power);
          if (out_tuser !== want.mod_error)
            report_mismatch("zero modulus flag", out_tuser, want.mod_error);
        end
        results_seen <= results_seen + 1;
      end
      out_tready <= (hold_cycles_left == 0) && !receiver_stall();
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_cycles_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cycles_left != 0) begin
      hold_cycles_left <= hold_cycles_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modular_exponentiation test failed");
      $finish;
    end
  end

  initial begin
    add_word(pack_operands(32'd5, 32'd3, 32'd13));
    add_word(pack_operands(32'd0, 32'd0, 32'd7));
    add_word(pack_operands(32'd0, 32'd5, 32'd7));
    add_word(pack_operands('1, '1, '1));
    add_word(pack_operands('1, 32'd0, 32'd1));
    add_word(pack_operands(32'd9, 32'd0, 32'd10));
    add_word(pack_operands(32'd7, 32'd0, 32'd0));
    add_word(pack_operands('1, '1, 32'd0));
    add_word(pack_operands(32'd0, 32'd0, 32'd0));
    add_word(pack_operands(32'd2, '1, '1));
    add_word(pack_operands('1, 32'd1, 32'hFFFF_FFFE));
    add_word(pack_operands(32'd100, 32'd1, 32'd7));
    add_word(pack_operands(32'd17, 32'd5, 32'd17));
    add_word(pack_operands(32'd3, 32'h8000_0000, 32'd1_000_000_007));
    add_word(pack_operands('1, '1, 32'd2));
    add_word(pack_operands(32'd1, '1, '1));
    add_word(pack_operands(32'd2, 32'd10, 32'd1024));
    add_word(pack_operands(32'd2, 32'd4294967290, 32'd4294967291));
    add_word(pack_operands(32'hFFFF_FFFE, 32'd2, '1));
    add_word(pack_operands(32'h8000_0000, 32'd3, 32'h8000_0000));
    add_word(pack_operands(32'h1234_5678, 32'hDEAD_BEEF, 32'h8000_0001));
    add_word(pack_operands('1, '1, 32'd1));
    for (int i = 0; i < RANDOM_WORDS; i++) add_word(random_operands());

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_tvalid || expected_powers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_powers.size() == 0) begin
      $display("modular_exponentiation test passed");
    end else begin
      $display("modular_exponentiation test failed");
    end
    $finish;
  end

endmodule
